@@ hdl/smau_pkg.sv @@
package smau_pkg;

  // Sizes fixed by the item fields.
  localparam int DIM_DEFAULT = 4;
  localparam int ELEM_W      = 16;
  localparam int FRAC_W      = ELEM_W / 2;
  localparam int RES_W       = 34;
  localparam int IDX_PORT_W  = 2;
  localparam int CMD_W       = 2;
  localparam int OP_W        = 2;
  localparam int ROWS_W      = 3;

  // Register port sizes.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 3'd4;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_OPERATION = 1'b0,
    REG_ROWS      = 1'b1
  } smau_reg_e;

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_RUN  = 2'd2
  } smau_cmd_e;

  // Operation register codes.
  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } smau_op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_PUSH
  } smau_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic issue;
    logic first;
    logic last;
    logic push;
    logic push_last;
  } smau_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sum_done;
    logic slot_free;
  } smau_sts_t;

  // Tag that travels with one term through the arithmetic pipeline.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } smau_tag_t;

endpackage

@@ hdl/small_matrix_arith_unit.sv @@
// Small matrix arithmetic unit: holds two DIM x DIM matrices A and B of signed
// Q8.8 elements and emits element sums, differences or the matrix product.
// Input items arrive on in_valid_i/in_stall_o: an item is taken at an edge with
// in_valid_i high and in_stall_o low. A write item stores one element of A or
// B; writes outside the matrix and unused commands are dropped.
// A run item emits one result item per element of the first rows_in_use rows
// (at most DIM), row-major, in Q18.16, with last_o set on the final one.
// in_stall_o stays high for the whole run.
// Each multiply result is built from DIM terms read one after another into the
// shared multiply-accumulate unit through read, multiply and accumulate stages;
// each sum or difference result has a single term, and the next element starts
// only after the current one is done. Results leave via an output register;
// while out_stall_i is high the held item stays unchanged and the run pauses
// until the slot frees. Reset clears both matrices to zero, sets operation to
// add and rows_in_use to four. Configuration is to be written over the register
// port between runs; the block itself does not enforce this.
module small_matrix_arith_unit
  import smau_pkg::*;
#(
  parameter int DIM = DIM_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [IDX_PORT_W-1:0]    row_i,
  input  logic [IDX_PORT_W-1:0]    col_i,
  input  logic signed [ELEM_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IDX_PORT_W-1:0]    out_row_o,
  output logic [IDX_PORT_W-1:0]    out_col_o,
  output logic signed [RES_W-1:0]  result_value_o,
  output logic                     last_o
);

  localparam int IDX_W = $clog2(DIM);

  smau_op_e          op;
  logic [ROWS_W-1:0] rows;
  smau_ctl_t         ctl;
  smau_sts_t         sts;
  logic [IDX_W-1:0]  r_idx, c_idx, k_idx;

  // Configuration registers.
  smau_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .op_o    (op),
    .rows_o  (rows)
  );

  // Run sequencer.
  smau_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .op_i       (op),
    .rows_i     (rows),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .r_o        (r_idx),
    .c_o        (c_idx),
    .k_o        (k_idx)
  );

  // Element stores, arithmetic pipeline and output register.
  smau_dp #(
    .DIM (DIM)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .r_i            (r_idx),
    .c_i            (c_idx),
    .k_i            (k_idx),
    .op_i           (op),
    .row_i          (row_i),
    .col_i          (col_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .result_value_o (result_value_o),
    .last_o         (last_o)
  );

endmodule

@@ hdl/smau_regs.sv @@
module smau_regs
  import smau_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output smau_op_e           op_o,
  output logic [ROWS_W-1:0]  rows_o
);

  logic [OP_W-1:0]   op_q;
  logic [ROWS_W-1:0] rows_q;
  logic              wr_en;
  smau_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = smau_reg_e'(paddr[2]);

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_ADD;
      rows_q <= ROWS_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_OPERATION: op_q   <= pwdata[OP_W-1:0];
        REG_ROWS:      rows_q <= pwdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_OPERATION: prdata = PDATA_W'(op_q);
      REG_ROWS:      prdata = PDATA_W'(rows_q);
      default:       prdata = '0;
    endcase
  end

  assign op_o   = smau_op_e'(op_q);
  assign rows_o = rows_q;

endmodule

@@ hdl/smau_ctrl.sv @@
module smau_ctrl
  import smau_pkg::*;
#(
  parameter int DIM = DIM_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [IDX_PORT_W-1:0]  row_i,
  input  logic [IDX_PORT_W-1:0]  col_i,
  input  smau_op_e               op_i,
  input  logic [ROWS_W-1:0]      rows_i,
  input  smau_sts_t              sts_i,
  output smau_ctl_t              ctl_o,
  output logic [$clog2(DIM)-1:0] r_o,
  output logic [$clog2(DIM)-1:0] c_o,
  output logic [$clog2(DIM)-1:0] k_o
);

  localparam int IDX_W = $clog2(DIM);
  localparam logic [IDX_W-1:0] DIM_LAST = IDX_W'(DIM - 1);

  smau_state_e      state_q, state_d;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d, last_r_q, last_r_d;
  logic [IDX_W-1:0] k_end;
  logic             accept, in_rng, run_go, k_last, elem_last, push_ok;

  // Items are taken only between runs.
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_rng     = (int'(row_i) < DIM) && (int'(col_i) < DIM);
  assign run_go     = accept && (cmd_i == CMD_RUN) && (rows_i != '0);

  // A product needs DIM terms, a sum or difference one.
  assign k_end     = (op_i == OP_MUL) ? DIM_LAST : '0;
  assign k_last    = (k_q == k_end);
  assign elem_last = (r_q == last_r_q) && (c_q == DIM_LAST);
  assign push_ok   = sts_i.slot_free &&
                     (((state_q == ST_DRAIN) && sts_i.sum_done) || (state_q == ST_PUSH));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (run_go) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (k_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.sum_done) begin
          if (!sts_i.slot_free) state_d = ST_PUSH;
          else                  state_d = elem_last ? ST_IDLE : ST_ISSUE;
        end
      end
      ST_PUSH: begin
        if (sts_i.slot_free) state_d = elem_last ? ST_IDLE : ST_ISSUE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands and counter updates.
  always_comb begin
    ctl_o    = '0;
    r_d      = r_q;
    c_d      = c_q;
    k_d      = k_q;
    last_r_d = last_r_q;

    ctl_o.wr_a = accept && (cmd_i == CMD_WR_A) && in_rng;
    ctl_o.wr_b = accept && (cmd_i == CMD_WR_B) && in_rng;

    if (run_go) begin
      r_d = '0;
      c_d = '0;
      k_d = '0;
      if (int'(rows_i) > DIM) last_r_d = DIM_LAST;
      else                    last_r_d = IDX_W'(int'(rows_i) - 1);
    end

    if (state_q == ST_ISSUE) begin
      ctl_o.issue = 1'b1;
      ctl_o.first = (k_q == '0);
      ctl_o.last  = k_last;
      k_d         = k_last ? '0 : k_q + 1'b1;
    end

    if (push_ok) begin
      ctl_o.push      = 1'b1;
      ctl_o.push_last = elem_last;
      if (c_q == DIM_LAST) begin
        c_d = '0;
        r_d = r_q + 1'b1;
      end else begin
        c_d = c_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      r_q      <= '0;
      c_q      <= '0;
      k_q      <= '0;
      last_r_q <= '0;
    end else begin
      state_q  <= state_d;
      r_q      <= r_d;
      c_q      <= c_d;
      k_q      <= k_d;
      last_r_q <= last_r_d;
    end
  end

  assign r_o = r_q;
  assign c_o = c_q;
  assign k_o = k_q;

  // A finished sum only comes back while the controller waits for it.
  a_sum_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.sum_done |-> (state_q == ST_DRAIN))
    else $error("sum finished outside of drain");

  // A result is never pushed into an occupied output slot.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.push |-> sts_i.slot_free)
    else $error("result pushed into a full output slot");

  // The term counter is back at zero whenever the controller is idle.
  a_k_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (k_q == '0))
    else $error("term counter not cleared");

  // The last result of a run ends the run.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.push && ctl_o.push_last) |=> (state_q == ST_IDLE))
    else $error("run continued after its last result");

endmodule

@@ hdl/smau_dp.sv @@
module smau_dp
  import smau_pkg::*;
#(
  parameter int DIM = DIM_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  smau_ctl_t                    ctl_i,
  output smau_sts_t                    sts_o,
  input  logic [$clog2(DIM)-1:0]       r_i,
  input  logic [$clog2(DIM)-1:0]       c_i,
  input  logic [$clog2(DIM)-1:0]       k_i,
  input  smau_op_e                     op_i,
  input  logic [IDX_PORT_W-1:0]        row_i,
  input  logic [IDX_PORT_W-1:0]        col_i,
  input  logic signed [ELEM_W-1:0]     value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [IDX_PORT_W-1:0]        out_row_o,
  output logic [IDX_PORT_W-1:0]        out_col_o,
  output logic signed [RES_W-1:0]      result_value_o,
  output logic                         last_o
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);

  logic signed [ELEM_W-1:0] mem_a_q [DEPTH];
  logic signed [ELEM_W-1:0] mem_b_q [DEPTH];
  logic [DEPTH-1:0]         vld_a_q, vld_b_q;

  logic [AW-1:0]            wr_addr, a_addr, b_addr;
  logic signed [ELEM_W-1:0] rd_a_q, rd_b_q, a_val, b_val;
  logic                     rd_a_vld_q, rd_b_vld_q, is_mul;

  logic signed [ELEM_W:0]     sum_ab, diff_ab;
  logic signed [2*ELEM_W-1:0] prod;
  logic signed [RES_W-1:0]    term_d, term_q, acc_q;
  smau_tag_t                  tag1_q, tag2_q;
  logic                       done_q;

  logic                       out_vld_q, out_last_q;
  logic [IDX_PORT_W-1:0]      out_row_q, out_col_q;
  logic signed [RES_W-1:0]    out_val_q;

  assign is_mul = (op_i == OP_MUL);

  // Row-major addresses for the write port and the two read ports.
  assign wr_addr = AW'(row_i) * AW'(DIM) + AW'(col_i);
  assign a_addr  = AW'(r_i) * AW'(DIM) + AW'(is_mul ? k_i : c_i);
  assign b_addr  = is_mul ? (AW'(k_i) * AW'(DIM) + AW'(c_i))
                          : (AW'(r_i) * AW'(DIM) + AW'(c_i));

  // Element stores with one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_a) mem_a_q[wr_addr] <= value_i;
    if (ctl_i.wr_b) mem_b_q[wr_addr] <= value_i;
    rd_a_q     <= mem_a_q[a_addr];
    rd_b_q     <= mem_b_q[b_addr];
    rd_a_vld_q <= vld_a_q[a_addr];
    rd_b_vld_q <= vld_b_q[b_addr];
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      vld_b_q <= '0;
    end else begin
      if (ctl_i.wr_a) vld_a_q[wr_addr] <= 1'b1;
      if (ctl_i.wr_b) vld_b_q[wr_addr] <= 1'b1;
    end
  end

  assign a_val = rd_a_vld_q ? rd_a_q : '0;
  assign b_val = rd_b_vld_q ? rd_b_q : '0;

  // Term of the selected operation, scaled to the result format.
  assign sum_ab  = (ELEM_W+1)'(a_val) + (ELEM_W+1)'(b_val);
  assign diff_ab = (ELEM_W+1)'(a_val) - (ELEM_W+1)'(b_val);
  assign prod    = a_val * b_val;

  always_comb begin
    case (op_i)
      OP_ADD:  term_d = RES_W'(sum_ab) <<< FRAC_W;
      OP_SUB:  term_d = RES_W'(diff_ab) <<< FRAC_W;
      OP_MUL:  term_d = RES_W'(prod);
      default: term_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
    if (tag2_q.vld) acc_q <= tag2_q.first ? term_q : acc_q + term_q;
  end

  // Tags follow each term through read, multiply and accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      done_q <= 1'b0;
    end else begin
      tag1_q <= '{vld: ctl_i.issue, first: ctl_i.first, last: ctl_i.last};
      tag2_q <= tag1_q;
      done_q <= tag2_q.vld && tag2_q.last;
    end
  end

  // Output register holds one result item until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.push) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      out_row_q  <= IDX_PORT_W'(r_i);
      out_col_q  <= IDX_PORT_W'(c_i);
      out_val_q  <= acc_q;
      out_last_q <= ctl_i.push_last;
    end
  end

  assign sts_o.sum_done  = done_q;
  assign sts_o.slot_free = !out_vld_q || !out_stall_i;

  assign out_valid_o    = out_vld_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign result_value_o = out_val_q;
  assign last_o         = out_last_q;

endmodule
